// ===== rtl/dmpes_pkg.sv =====
`default_nettype none

package dmpes_pkg;

  // Pin bits of the three half-bridges.
  localparam logic [5:0] P_AH = 6'h01;
  localparam logic [5:0] P_AL = 6'h02;
  localparam logic [5:0] P_BH = 6'h04;
  localparam logic [5:0] P_BL = 6'h08;
  localparam logic [5:0] P_CH = 6'h10;
  localparam logic [5:0] P_CL = 6'h20;

  // Motor modes.
  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_FWD  = 3'd1;
  localparam logic [2:0] MODE_BWD  = 3'd2;
  localparam logic [2:0] MODE_BRK  = 3'd3;
  localparam logic [2:0] MODE_SL   = 3'd4;
  localparam logic [2:0] MODE_SR   = 3'd5;

  // Request kinds.
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_MODE  = 1'b1;

  // PWM phases.
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_OVF = 2'd2;
  localparam logic [1:0] PH_BAD = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_EDGE_A = 2'd0;
  localparam logic [1:0] REG_EDGE_B = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [15:0] MIN_PHASE     = 16'd10;
  localparam logic [6:0]  REFRESH_LIMIT = 7'd100;
  localparam logic [7:0]  SWITCH_WAIT   = 8'd200;
  localparam logic [7:0]  SPIN_WAIT     = 8'd10;

  localparam int TIMER_BITS_DEF = 16;
  localparam int NC_W = 16;

  typedef struct packed {
    logic [15:0] edge_a;
    logic [15:0] edge_b;
    logic [15:0] period;
    logic [15:0] thresh;
  } cfg_t;

  // Snapshot list as it is built: current pins plus up to four snapshots.
  typedef struct packed {
    logic [5:0]       ps;
    logic [3:0][5:0]  pins;
    logic [3:0][7:0]  wt;
    logic [1:0]       top;
  } work_t;

  // Snapshot list handed to the output buffer.
  typedef struct packed {
    logic [3:0][5:0]  pins;
    logic [3:0][7:0]  wt;
    logic [1:0]       top;
    logic             is_event;
    logic [15:0]      cmp;
  } res_t;

  function automatic work_t snap_clr(work_t s, logic [5:0] m);
    s.ps = s.ps & ~m;
    s.pins[s.top] = s.ps;
    return s;
  endfunction

  function automatic work_t snap_set(work_t s, logic [5:0] m);
    s.ps = s.ps | m;
    s.pins[s.top] = s.ps;
    return s;
  endfunction

  // A wait opens a new snapshot, as long as there is room for one.
  function automatic work_t snap_pause(work_t s, logic [7:0] us);
    if (s.top != 2'd3) begin
      s.top = s.top + 2'd1;
      s.pins[s.top] = s.ps;
      s.wt[s.top] = us;
    end
    return s;
  endfunction

  function automatic work_t edge_a_act(work_t s, logic [2:0] mode);
    case (mode)
      MODE_FWD: s = snap_clr(s, P_CH);
      MODE_BWD: s = snap_clr(s, P_CL);
      MODE_SL: begin
        s = snap_clr(s, P_BH);
        s = snap_pause(s, SPIN_WAIT);
        s = snap_set(s, P_BL);
      end
      MODE_SR: begin
        s = snap_clr(s, P_BL);
        s = snap_pause(s, SPIN_WAIT);
        s = snap_set(s, P_BH);
      end
      default: s = s;
    endcase
    return s;
  endfunction

  function automatic work_t edge_b_act(work_t s, logic [2:0] mode);
    case (mode)
      MODE_FWD: s = snap_clr(s, P_AH);
      MODE_BWD: s = snap_clr(s, P_AL);
      MODE_SL:  s = snap_clr(s, P_CH);
      MODE_SR:  s = snap_clr(s, P_CL);
      default:  s = s;
    endcase
    return s;
  endfunction

  // Pin changes at the period overflow, before any refresh drop.
  function automatic work_t ovf_act(work_t s, logic [2:0] mode);
    case (mode)
      MODE_BWD: s = snap_set(s, P_AL | P_BH | P_CL);
      MODE_FWD: s = snap_set(s, P_AH | P_BL | P_CH);
      MODE_SL: begin
        s = snap_set(s, P_AL);
        s = snap_clr(s, P_BL);
        s = snap_pause(s, SPIN_WAIT);
        s = snap_set(s, P_BH | P_CH);
      end
      MODE_SR: begin
        s = snap_set(s, P_AH);
        s = snap_clr(s, P_BH);
        s = snap_pause(s, SPIN_WAIT);
        s = snap_set(s, P_BL | P_CL);
      end
      default: s = s;
    endcase
    return s;
  endfunction

  // High-side drivers dropped by a charge-pump refresh.
  function automatic logic [5:0] drop_mask(logic [2:0] mode);
    logic [5:0] m;
    case (mode)
      MODE_BWD: m = P_BH;
      MODE_FWD: m = P_AH | P_CH;
      MODE_SL:  m = P_BH | P_CH;
      MODE_SR:  m = P_BH | P_CH;
      default:  m = '0;
    endcase
    return m;
  endfunction

  // Dead-time switch sequence for a mode change.
  function automatic work_t mode_seq(work_t s, logic [2:0] m);
    case (m)
      MODE_FWD: begin
        s = snap_clr(s, P_AL | P_BH | P_CL);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_BL);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_AH);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_CH);
      end
      MODE_BWD: begin
        s = snap_clr(s, P_AH | P_BL | P_CH);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_BH);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_AL);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_CL);
      end
      MODE_BRK: begin
        s = snap_clr(s, P_AH | P_BH | P_CH);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_AL | P_BL | P_CL);
      end
      MODE_SL: begin
        s = snap_clr(s, P_AH | P_BL | P_BH | P_CL);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_AL);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_CH);
      end
      default: begin
        s = snap_clr(s, P_AL | P_BL | P_BH | P_CH);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_AH);
        s = snap_pause(s, SWITCH_WAIT);
        s = snap_set(s, P_CL);
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dmpes_in_stage.sv =====
`default_nettype none

module dmpes_in_stage
  import dmpes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic       in_type,
  input  wire logic [2:0] in_mode,
  input  wire logic       consume,
  output logic            valid,
  output logic            req_type,
  output logic [2:0]      new_mode
);

  logic       v_r;
  logic       type_r;
  logic [2:0] mode_r;

  // The register takes a new word whenever it is empty or being drained.
  assign in_tready = !v_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      v_r <= 1'b1;
    end else if (consume) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      type_r <= in_type;
      mode_r <= in_mode;
    end
  end

  assign valid    = v_r;
  assign req_type = type_r;
  assign new_mode = mode_r;

endmodule

`default_nettype wire

// ===== rtl/dmpes_engine.sv =====
`default_nettype none

module dmpes_engine
  import dmpes_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       fire,
  input  wire logic       req_type,
  input  wire logic [2:0] new_mode,
  output logic            produce,
  output res_t            res
);

  logic [2:0]            mode_r, mode_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [6:0]            rc_r, rc_nxt;
  logic [TIMER_BITS-1:0] cp_r, cp_nxt;
  logic [5:0]            pin_r;

  work_t       s;
  logic        a_first;
  logic [15:0] lo;
  logic [15:0] hi;
  logic [15:0] dur;
  logic [1:0]  ph;

  // Build the whole snapshot list for the word in the input register.
  always_comb begin
    s         = '0;
    s.ps      = pin_r;
    s.pins[0] = pin_r;
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    rc_nxt    = rc_r;
    cp_nxt    = cp_r;
    produce   = 1'b0;
    a_first   = cfg.edge_a < cfg.edge_b;
    lo        = a_first ? cfg.edge_a : cfg.edge_b;
    hi        = a_first ? cfg.edge_b : cfg.edge_a;
    dur       = '0;
    ph        = (phase_r == PH_BAD) ? PH_FIRST : phase_r;

    if (req_type == REQ_EVENT) begin
      produce = 1'b1;
      // Earlier edge; a short gap folds the next phase into this event.
      if (ph == PH_FIRST) begin
        s = a_first ? edge_a_act(s, mode_r) : edge_b_act(s, mode_r);
        dur = hi - lo;
        if (dur < MIN_PHASE) begin
          ph = PH_SECOND;
        end
      end
      // Later edge.
      if (ph == PH_SECOND) begin
        s = a_first ? edge_b_act(s, mode_r) : edge_a_act(s, mode_r);
        dur = (cfg.period > hi) ? cfg.period - hi : '0;
        if (dur < MIN_PHASE) begin
          ph = PH_OVF;
        end
      end
      // Period overflow with the charge-pump refresh count.
      if (ph == PH_OVF) begin
        s = ovf_act(s, mode_r);
        if (mode_r == MODE_FWD || mode_r == MODE_BWD ||
            mode_r == MODE_SL || mode_r == MODE_SR) begin
          if (cfg.edge_a >= cfg.thresh || cfg.edge_b >= cfg.thresh) begin
            rc_nxt = rc_r + 7'd1;
            if (rc_nxt > REFRESH_LIMIT) begin
              s = snap_clr(s, drop_mask(mode_r));
              rc_nxt = '0;
            end
          end
        end
        dur = (lo < MIN_PHASE) ? MIN_PHASE : lo;
        ph = PH_FIRST;
      end else begin
        ph = ph + 2'd1;
      end
      phase_nxt = ph;
      cp_nxt = cp_r + TIMER_BITS'(dur);
    end else begin
      // Mode command: only a valid new mode runs a sequence.
      if ((new_mode inside {[MODE_FWD:MODE_SR]}) && new_mode != mode_r) begin
        produce  = 1'b1;
        s        = mode_seq(s, new_mode);
        mode_nxt = new_mode;
      end
    end

    res.pins     = s.pins;
    res.wt       = s.wt;
    res.top      = s.top;
    res.is_event = (req_type == REQ_EVENT);
    res.cmp      = NC_W'(cp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      phase_r <= PH_FIRST;
      rc_r    <= '0;
      cp_r    <= '0;
      pin_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      rc_r    <= rc_nxt;
      cp_r    <= cp_nxt;
      pin_r   <= s.ps;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmpes_out_buf.sv =====
`default_nettype none

module dmpes_out_buf
  import dmpes_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire res_t   res,
  output logic        free,
  output logic        out_tvalid,
  input  wire logic   out_tready,
  output logic [5:0]  pin_drive,
  output logic [7:0]  wait_us,
  output logic [15:0] next_compare,
  output logic        compare_valid,
  output logic        last_result
);

  logic            v_r;
  logic [1:0]      idx_r;
  logic [3:0][5:0] pins_r;
  logic [3:0][7:0] wt_r;
  logic [1:0]      top_r;
  logic            ev_r;
  logic [15:0]     cmp_r;

  assign last_result   = (idx_r == top_r);
  assign compare_valid = last_result && ev_r;
  assign pin_drive     = pins_r[idx_r];
  assign wait_us       = wt_r[idx_r];
  assign next_compare  = compare_valid ? cmp_r : '0;
  assign out_tvalid    = v_r;

  // Free for a new list once the last word of the current one goes out.
  assign free = !v_r || (out_tready && last_result);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      v_r   <= 1'b1;
      idx_r <= '0;
    end else if (v_r && out_tready) begin
      if (last_result) begin
        v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pins_r <= res.pins;
      wt_r   <= res.wt;
      top_r  <= res.top;
      ev_r   <= res.is_event;
      cmp_r  <= res.cmp;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_motor_pwm_edge_sequencer.sv =====
`default_nettype none

// Drives two brushed motors from three half-bridges with a shared middle leg.
// An input word is either a compare-match event (tuser 0) or a mode command
// (tuser 1, mode in tdata). Each word yields one to four pin snapshots on the
// output, the last one flagged by tlast; on events the last snapshot also
// carries the next compare point and sets tuser. A command that repeats the
// current mode, or names no mode, yields nothing. The whole snapshot list is
// computed combinationally from the input register and held in an output buffer
// that sends one word per cycle while out_tready is high. Events yield one to
// three snapshots, mode changes up to four. A new input word is taken while the
// previous list drains.
// Registers at byte addresses 0, 4, 8, 12: edge A point, edge B point,
// PWM period, refresh threshold, all 16 bits.
module dual_motor_pwm_edge_sequencer
  import dmpes_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [2:0] new_mode, rest zero
  input  wire logic        in_tuser,    // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [5:0] pin_drive, [13:6] wait_us,
                                        // [29:14] next_compare, rest zero
  output logic             out_tuser,   // [0] compare_valid
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t        cfg_r;
  logic        st_valid;
  logic        st_type;
  logic [2:0]  st_mode;
  logic        consume;
  logic        produce;
  logic        free;
  res_t        res;
  logic [5:0]  pin_drive;
  logic [7:0]  wait_us;
  logic [15:0] next_compare;
  logic        compare_valid;
  logic        last_result;

  // Configuration registers.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_a <= 16'd500;
      cfg_r.edge_b <= 16'd4000;
      cfg_r.period <= 16'd8192;
      cfg_r.thresh <= 16'd7373;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[3:2])
        REG_EDGE_A: cfg_r.edge_a <= cfg_pwdata[15:0];
        REG_EDGE_B: cfg_r.edge_b <= cfg_pwdata[15:0];
        REG_PERIOD: cfg_r.period <= cfg_pwdata[15:0];
        REG_THRESH: cfg_r.thresh <= cfg_pwdata[15:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_EDGE_A: cfg_prdata = {16'd0, cfg_r.edge_a};
      REG_EDGE_B: cfg_prdata = {16'd0, cfg_r.edge_b};
      REG_PERIOD: cfg_prdata = {16'd0, cfg_r.period};
      REG_THRESH: cfg_prdata = {16'd0, cfg_r.thresh};
      default:    cfg_prdata = '0;
    endcase
  end

  // The registered word is processed once the output buffer can take its list.
  assign consume = st_valid && free;

  dmpes_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_type   (in_tuser),
    .in_mode   (in_tdata[2:0]),
    .consume   (consume),
    .valid     (st_valid),
    .req_type  (st_type),
    .new_mode  (st_mode)
  );

  dmpes_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fire     (consume),
    .req_type (st_type),
    .new_mode (st_mode),
    .produce  (produce),
    .res      (res)
  );

  dmpes_out_buf u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (consume && produce),
    .res           (res),
    .free          (free),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .pin_drive     (pin_drive),
    .wait_us       (wait_us),
    .next_compare  (next_compare),
    .compare_valid (compare_valid),
    .last_result   (last_result)
  );

  assign out_tdata = {2'b00, next_compare, wait_us, pin_drive};
  assign out_tuser = compare_valid;
  assign out_tlast = last_result;

endmodule

`default_nettype wire

// ===== bench/dual_motor_pwm_edge_sequencer_tb.sv =====
`timescale 1ns / 100ps

import dmpes_pkg::*;

// One expected output word: a pin snapshot plus its side fields.
typedef struct {
  logic [5:0]  pin;
  logic [7:0]  wt;
  logic [15:0] cmp;
  logic        cmp_ok;
  logic        last;
} pin_snapshot_t;

// Tracks the sequencer state, predicts the snapshots of every accepted word
// and checks the output words against them in order.
class snapshot_checker;
  logic [15:0] edge_a, edge_b, period, thresh;
  logic [2:0]  mode;
  logic [1:0]  phase;
  logic [6:0]  refresh_cnt;
  logic [15:0] cmp_point;
  logic [5:0]  pins;
  logic [5:0]  list_pins[4];
  logic [7:0]  list_wait[4];
  int          list_len;
  pin_snapshot_t expected_snaps[$];
  int          errors;

  function new();
    edge_a      = 16'd500;
    edge_b      = 16'd4000;
    period      = 16'd8192;
    thresh      = 16'd7373;
    mode        = MODE_NONE;
    phase       = PH_FIRST;
    refresh_cnt = '0;
    cmp_point   = '0;
    pins        = '0;
    list_len    = 0;
    errors      = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] value);
    case (idx)
      REG_EDGE_A: edge_a = value;
      REG_EDGE_B: edge_b = value;
      REG_PERIOD: period = value;
      default:    thresh = value;
    endcase
  endfunction

  function int pending();
    return expected_snaps.size();
  endfunction

  // Snapshot list helpers: pin changes land in the newest snapshot,
  // and only a wait opens another one.
  function void open_list();
    list_len     = 1;
    list_pins[0] = pins;
    list_wait[0] = '0;
  endfunction

  function void drop(logic [5:0] m);
    pins = pins & ~m;
    list_pins[list_len-1] = pins;
  endfunction

  function void raise(logic [5:0] m);
    pins = pins | m;
    list_pins[list_len-1] = pins;
  endfunction

  function void gap(logic [7:0] us);
    if (list_len < 4) begin
      list_pins[list_len] = pins;
      list_wait[list_len] = us;
      list_len++;
    end
  endfunction

  function void edge_a_pins();
    case (mode)
      MODE_FWD: drop(P_CH);
      MODE_BWD: drop(P_CL);
      MODE_SL: begin
        drop(P_BH);
        gap(SPIN_WAIT);
        raise(P_BL);
      end
      MODE_SR: begin
        drop(P_BL);
        gap(SPIN_WAIT);
        raise(P_BH);
      end
      default: ;
    endcase
  endfunction

  function void edge_b_pins();
    case (mode)
      MODE_FWD: drop(P_AH);
      MODE_BWD: drop(P_AL);
      MODE_SL:  drop(P_CH);
      MODE_SR:  drop(P_CL);
      default:  ;
    endcase
  endfunction

  // Charge-pump refresh: count high-duty overflows, drop the high sides
  // once the count passes the limit.
  function void charge_pump(logic [5:0] m);
    if (edge_a >= thresh || edge_b >= thresh) begin
      refresh_cnt = refresh_cnt + 7'd1;
      if (refresh_cnt > REFRESH_LIMIT) begin
        drop(m);
        refresh_cnt = '0;
      end
    end
  endfunction

  function void overflow_pins();
    case (mode)
      MODE_BWD: begin
        raise(P_AL | P_BH | P_CL);
        charge_pump(P_BH);
      end
      MODE_FWD: begin
        raise(P_AH | P_BL | P_CH);
        charge_pump(P_AH | P_CH);
      end
      MODE_SL: begin
        raise(P_AL);
        drop(P_BL);
        gap(SPIN_WAIT);
        raise(P_BH | P_CH);
        charge_pump(P_BH | P_CH);
      end
      MODE_SR: begin
        raise(P_AH);
        drop(P_BH);
        gap(SPIN_WAIT);
        raise(P_BL | P_CL);
        charge_pump(P_BH | P_CH);
      end
      default: ;
    endcase
  endfunction

  // Dead-time switch sequence of a mode change.
  function void switch_mode(logic [2:0] m);
    open_list();
    case (m)
      MODE_FWD: begin
        drop(P_AL | P_BH | P_CL);
        gap(SWITCH_WAIT); raise(P_BL);
        gap(SWITCH_WAIT); raise(P_AH);
        gap(SWITCH_WAIT); raise(P_CH);
      end
      MODE_BWD: begin
        drop(P_AH | P_BL | P_CH);
        gap(SWITCH_WAIT); raise(P_BH);
        gap(SWITCH_WAIT); raise(P_AL);
        gap(SWITCH_WAIT); raise(P_CL);
      end
      MODE_BRK: begin
        drop(P_AH | P_BH | P_CH);
        gap(SWITCH_WAIT); raise(P_AL | P_BL | P_CL);
      end
      MODE_SL: begin
        drop(P_AH | P_BL | P_BH | P_CL);
        gap(SWITCH_WAIT); raise(P_AL);
        gap(SWITCH_WAIT); raise(P_CH);
      end
      default: begin
        drop(P_AL | P_BL | P_BH | P_CH);
        gap(SWITCH_WAIT); raise(P_AH);
        gap(SWITCH_WAIT); raise(P_CL);
      end
    endcase
    mode = m;
  endfunction

  // One compare match: run phases until one is long enough to wait for.
  function void step_pwm();
    logic        a_first;
    logic [15:0] lo, hi, dur;
    logic [1:0]  ph;
    a_first = edge_a < edge_b;
    lo      = a_first ? edge_a : edge_b;
    hi      = a_first ? edge_b : edge_a;
    ph      = (phase == PH_BAD) ? PH_FIRST : phase;
    dur     = '0;
    open_list();
    if (ph == PH_FIRST) begin
      if (a_first) edge_a_pins(); else edge_b_pins();
      dur = hi - lo;
      if (dur < MIN_PHASE) ph = PH_SECOND;
    end
    if (ph == PH_SECOND) begin
      if (a_first) edge_b_pins(); else edge_a_pins();
      dur = (period > hi) ? period - hi : 16'd0;
      if (dur < MIN_PHASE) ph = PH_OVF;
    end
    if (ph == PH_OVF) begin
      overflow_pins();
      dur = (lo < MIN_PHASE) ? MIN_PHASE : lo;
      ph  = PH_FIRST;
    end else begin
      ph = ph + 2'd1;
    end
    phase     = ph;
    cmp_point = cmp_point + dur;
  endfunction

  // Called for every accepted input word.
  function void note_word(logic req, logic [2:0] m);
    pin_snapshot_t s;
    logic is_event;
    is_event = (req == REQ_EVENT);
    if (is_event) begin
      step_pwm();
    end else begin
      if (m < MODE_FWD || m > MODE_SR || m == mode) return;
      switch_mode(m);
    end
    for (int k = 0; k < list_len; k++) begin
      s.pin    = list_pins[k];
      s.wt     = list_wait[k];
      s.last   = (k == list_len - 1);
      s.cmp_ok = s.last && is_event;
      s.cmp    = s.cmp_ok ? cmp_point : 16'd0;
      expected_snaps.push_back(s);
    end
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Called for every accepted output word.
  task check_word(logic [5:0] pin, logic [7:0] wt, logic [15:0] cmp, logic cmp_ok,
                  logic last);
    pin_snapshot_t e;
    if (expected_snaps.size() == 0) begin
      report("output word with no snapshot expected");
      return;
    end
    e = expected_snaps.pop_front();
    if (pin !== e.pin)
      report($sformatf("pin_drive got %h expected %h", pin, e.pin));
    if (wt !== e.wt)
      report($sformatf("wait_us got %0d expected %0d", wt, e.wt));
    if (cmp !== e.cmp)
      report($sformatf("next_compare got %h expected %h", cmp, e.cmp));
    if (cmp_ok !== e.cmp_ok)
      report($sformatf("compare_valid got %b expected %b", cmp_ok, e.cmp_ok));
    if (last !== e.last)
      report($sformatf("last_result got %b expected %b", last, e.last));
  endtask
endclass

module dual_motor_pwm_edge_sequencer_tb;

  // Mode values that name no mode.
  localparam logic [2:0] NO_MODE_6 = 3'd6;
  localparam logic [2:0] NO_MODE_7 = 3'd7;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  snapshot_checker board = new();

  int   send_idle_pct = 36;
  int   recv_idle_pct = 55;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  dual_motor_pwm_edge_sequencer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [2:0] new_mode, rest zero
    .in_tuser    (in_tuser),     // [0] req_type
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [5:0] pin_drive, [13:6] wait_us, [29:14] next_compare
    .out_tuser   (out_tuser),    // [0] compare_valid
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Receiver: random back-pressure, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every accepted output word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_word(out_tdata[5:0], out_tdata[13:6], out_tdata[29:14], out_tuser,
                       out_tlast);
  end

  // Entered and left at a falling edge; the valid stays high on return.
  task automatic push_word(input logic req, input logic [2:0] m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'd0, m};
    do @(posedge clk); while (!in_tready);
    board.note_word(req, m);
    @(negedge clk);
  endtask

  task automatic random_word(input int mode_pct);
    logic       req;
    logic [2:0] m;
    if ($urandom_range(0, 99) < mode_pct) begin
      req = REQ_MODE;
      if ($urandom_range(0, 9) == 0)
        m = 3'($urandom_range(0, 7));
      else
        m = 3'($urandom_range(MODE_FWD, MODE_SR));
    end else begin
      req = REQ_EVENT;
      m   = 3'($urandom_range(0, 7));
    end
    push_word(req, m);
  endtask

  // Setup and access cycle of one register write.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every expected word, then let dropped commands clear the block.
  task automatic settle();
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_point(input int floor);
    case ($urandom_range(0, 3))
      0:       return 16'(floor);
      1:       return 16'($urandom_range(floor, floor + 40));
      2:       return 16'($urandom_range(floor, 65535));
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin
    logic [3:0]  directed [24];
    logic [15:0] a, b, per, th;
    int          n_items;
    int          mode_pct;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_EVENT;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings: events before any mode, commands that
    // name no mode, a repeated mode, and a full PWM cycle in every mode but brake.
    directed = '{
      {REQ_EVENT, MODE_NONE}, {REQ_MODE, MODE_NONE}, {REQ_MODE, NO_MODE_6},
      {REQ_MODE, NO_MODE_7},  {REQ_MODE, MODE_BRK},  {REQ_EVENT, MODE_BRK},
      {REQ_MODE, MODE_BRK},   {REQ_MODE, MODE_FWD},  {REQ_EVENT, MODE_NONE},
      {REQ_EVENT, NO_MODE_7}, {REQ_EVENT, MODE_NONE}, {REQ_MODE, MODE_FWD},
      {REQ_MODE, MODE_BWD},   {REQ_EVENT, MODE_NONE}, {REQ_EVENT, MODE_NONE},
      {REQ_EVENT, MODE_NONE}, {REQ_MODE, MODE_SL},   {REQ_EVENT, MODE_NONE},
      {REQ_EVENT, MODE_NONE}, {REQ_EVENT, MODE_NONE}, {REQ_MODE, MODE_SR},
      {REQ_EVENT, MODE_NONE}, {REQ_EVENT, MODE_NONE}, {REQ_EVENT, MODE_NONE}
    };
    foreach (directed[i]) push_word(directed[i][3], directed[i][2:0]);
    in_tvalid <= 1'b0;

    // Random phases, each with its own register settings.
    for (int p = 0; p < 9; p++) begin
      settle();
      if (p < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 55;
      end else if (p < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n_items  = 28;
      mode_pct = 25;
      case (p)
        // Equal edges at zero: edge B goes first, both phases merge.
        0: begin a = 16'd0;     b = 16'd0;     per = 16'd20;    th = 16'hFFFF; end
        // Everything at the top: edge at the period, compare wraps.
        1: begin a = 16'hFFFF;  b = 16'hFFFF;  per = 16'hFFFF;  th = 16'hFFFF; end
        // Edges past a short period: one overflow per event, refresh counts.
        2: begin
          a = 16'd100; b = 16'd100; per = 16'd20; th = 16'd0;
          n_items  = 130;
          mode_pct = 5;
        end
        // Short phases around the minimum length.
        3: begin a = 16'd9;     b = 16'd19;    per = 16'd29;    th = 16'd0;    end
        default: begin
          a   = pick_point(0);
          b   = pick_point(0);
          per = pick_point(20);
          th  = ($urandom_range(0, 1) == 1) ? pick_point(0) : 16'($urandom_range(0, 600));
        end
      endcase
      write_reg(REG_EDGE_A, a);
      write_reg(REG_EDGE_B, b);
      write_reg(REG_PERIOD, per);
      write_reg(REG_THRESH, th);
      if (p == 2) push_word(REQ_MODE, MODE_SL);
      // Long receiver hold-off while words keep coming.
      if (p == 6) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      repeat (n_items) random_word(mode_pct);
      in_tvalid <= 1'b0;
    end

    settle();
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
